// ===== design/dcv_pkg.sv =====
// Package of shared types, codes and code tables for the DCT coefficient VLC decoder.
package dcv_pkg;

    typedef enum logic [3:0] {
        SUB_TOP,
        SUB_A,
        SUB_B,
        SUB_C,
        SUB_D,
        SUB_E,
        SUB_F,
        SUB_G,
        SUB_NONE
    } sub_t;

    typedef struct packed {
        logic [6:0] run;
        logic [5:0] mag;
        logic [4:0] len;
    } entry_t;

    localparam logic [6:0] RUN_EOB = 7'd64;
    localparam logic [6:0] RUN_ESC = 7'd65;

    function automatic entry_t ent(input int r, input int m, input int l);
        entry_t e;
        e.run = 7'(r);
        e.mag = 6'(m);
        e.len = 5'(l);
        return e;
    endfunction

    function automatic entry_t tb_top(input logic [3:0] i);
        entry_t e;
        case (i)
            4'd0: e = ent(0, 2, 4);
            4'd1: e = ent(2, 1, 4);
            4'd2, 4'd3: e = ent(1, 1, 3);
            4'd4, 4'd5, 4'd6, 4'd7: e = ent(64, 0, 2);
            default: e = ent(0, 1, 2);
        endcase
        return e;
    endfunction

    function automatic entry_t tb_a(input logic [5:0] i);
        entry_t e;
        case (i)
            6'd4, 6'd5: e = ent(2, 2, 7);
            6'd6, 6'd7: e = ent(9, 1, 7);
            6'd8, 6'd9: e = ent(0, 4, 7);
            6'd10, 6'd11: e = ent(8, 1, 7);
            6'd12, 6'd13, 6'd14, 6'd15: e = ent(7, 1, 6);
            6'd16, 6'd17, 6'd18, 6'd19: e = ent(6, 1, 6);
            6'd20, 6'd21, 6'd22, 6'd23: e = ent(1, 2, 6);
            6'd24, 6'd25, 6'd26, 6'd27: e = ent(5, 1, 6);
            6'd28: e = ent(13, 1, 8);
            6'd29: e = ent(0, 6, 8);
            6'd30: e = ent(12, 1, 8);
            6'd31: e = ent(11, 1, 8);
            6'd32: e = ent(3, 2, 8);
            6'd33: e = ent(1, 3, 8);
            6'd34: e = ent(0, 5, 8);
            6'd35: e = ent(10, 1, 8);
            6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43:
                e = ent(0, 3, 5);
            6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51:
                e = ent(4, 1, 5);
            6'd52, 6'd53, 6'd54, 6'd55, 6'd56, 6'd57, 6'd58, 6'd59:
                e = ent(3, 1, 5);
            default: e = ent(65, 0, 6);
        endcase
        return e;
    endfunction

    function automatic entry_t tb_b(input logic [2:0] i);
        entry_t e;
        case (i)
            3'd0: e = ent(16, 1, 10);
            3'd1: e = ent(5, 2, 10);
            3'd2: e = ent(0, 7, 10);
            3'd3: e = ent(2, 3, 10);
            3'd4: e = ent(1, 4, 10);
            3'd5: e = ent(15, 1, 10);
            3'd6: e = ent(14, 1, 10);
            default: e = ent(4, 2, 10);
        endcase
        return e;
    endfunction

    function automatic entry_t tb_c(input logic [3:0] i);
        entry_t e;
        case (i)
            4'd0: e = ent(0, 11, 12);
            4'd1: e = ent(8, 2, 12);
            4'd2: e = ent(4, 3, 12);
            4'd3: e = ent(0, 10, 12);
            4'd4: e = ent(2, 4, 12);
            4'd5: e = ent(7, 2, 12);
            4'd6: e = ent(21, 1, 12);
            4'd7: e = ent(20, 1, 12);
            4'd8: e = ent(0, 9, 12);
            4'd9: e = ent(19, 1, 12);
            4'd10: e = ent(18, 1, 12);
            4'd11: e = ent(1, 5, 12);
            4'd12: e = ent(3, 3, 12);
            4'd13: e = ent(0, 8, 12);
            4'd14: e = ent(6, 2, 12);
            default: e = ent(17, 1, 12);
        endcase
        return e;
    endfunction

    function automatic entry_t tb_d(input logic [3:0] i);
        entry_t e;
        case (i)
            4'd0: e = ent(10, 2, 13);
            4'd1: e = ent(9, 2, 13);
            4'd2: e = ent(5, 3, 13);
            4'd3: e = ent(3, 4, 13);
            4'd4: e = ent(2, 5, 13);
            4'd5: e = ent(1, 7, 13);
            4'd6: e = ent(1, 6, 13);
            4'd7: e = ent(0, 15, 13);
            4'd8: e = ent(0, 14, 13);
            4'd9: e = ent(0, 13, 13);
            4'd10: e = ent(0, 12, 13);
            4'd11: e = ent(26, 1, 13);
            4'd12: e = ent(25, 1, 13);
            4'd13: e = ent(24, 1, 13);
            4'd14: e = ent(23, 1, 13);
            default: e = ent(22, 1, 13);
        endcase
        return e;
    endfunction

    function automatic entry_t tb_e(input logic [3:0] i);
        entry_t e;
        e = ent(31 - int'(i), 0, 14);
        e.run = 7'd0;
        e.mag = 6'(31 - int'(i));
        return e;
    endfunction

    function automatic entry_t tb_f(input logic [3:0] i);
        entry_t e;
        case (i)
            4'd0: e = ent(0, 40, 15);
            4'd1: e = ent(0, 39, 15);
            4'd2: e = ent(0, 38, 15);
            4'd3: e = ent(0, 37, 15);
            4'd4: e = ent(0, 36, 15);
            4'd5: e = ent(0, 35, 15);
            4'd6: e = ent(0, 34, 15);
            4'd7: e = ent(0, 33, 15);
            4'd8: e = ent(0, 32, 15);
            4'd9: e = ent(1, 14, 15);
            4'd10: e = ent(1, 13, 15);
            4'd11: e = ent(1, 12, 15);
            4'd12: e = ent(1, 11, 15);
            4'd13: e = ent(1, 10, 15);
            4'd14: e = ent(1, 9, 15);
            default: e = ent(1, 8, 15);
        endcase
        return e;
    endfunction

    function automatic entry_t tb_g(input logic [3:0] i);
        entry_t e;
        case (i)
            4'd0: e = ent(1, 18, 16);
            4'd1: e = ent(1, 17, 16);
            4'd2: e = ent(1, 16, 16);
            4'd3: e = ent(1, 15, 16);
            4'd4: e = ent(6, 3, 16);
            4'd5: e = ent(16, 2, 16);
            4'd6: e = ent(15, 2, 16);
            4'd7: e = ent(14, 2, 16);
            4'd8: e = ent(13, 2, 16);
            4'd9: e = ent(12, 2, 16);
            4'd10: e = ent(11, 2, 16);
            4'd11: e = ent(31, 1, 16);
            4'd12: e = ent(30, 1, 16);
            4'd13: e = ent(29, 1, 16);
            4'd14: e = ent(28, 1, 16);
            default: e = ent(27, 1, 16);
        endcase
        return e;
    endfunction

endpackage

// ===== design/dct_coeff_vlc_decoder.sv =====
// Top level of the MPEG DCT coefficient VLC decoder (Table B-14, non-first form).
// Pipeline: three registered stages from input request to output request (classify, lookup, sign).
// Throughput: one code per cycle without output stalls; each stage advances when it is empty or its
// successor takes its request, so bubbles close up while the output stalls.
// Stalls: with all three stages full, an output stall halts the pipe and drops s_axis_tready.
// Reset: rst_n clears the stage valid bits only; payload registers are not reset.
module dct_coeff_vlc_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [16:0] bit_window, [23:17] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [6:0] run_length, [13:7] level_value, [18:14] bits_used
    output logic [0:0]  m_axis_tuser   // [0] code_invalid
);

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [16:0]       win1_reg, win2_reg;
    dcv_pkg::sub_t     sub1_reg, sub_next;
    logic [5:0]        idx1_reg, idx_next;
    dcv_pkg::entry_t   ent2_reg, ent_next;
    logic              inv2_reg;
    logic [6:0]        run3_reg, run_next;
    logic [6:0]        lvl3_reg, lvl_next;
    logic [4:0]        bits3_reg, bits_next;
    logic              inv3_reg;
    logic [15:0]       code;
    logic [4:0]        sh;
    logic              neg;

    assign rdy3 = !v3_reg || m_axis_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign code = s_axis_tdata[16:1];

    always_comb
    begin
        sub_next = dcv_pkg::SUB_NONE;
        idx_next = 6'd0;
        if (code[15:14] != 2'd0)
        begin
            sub_next = dcv_pkg::SUB_TOP;
            idx_next = {2'b00, code[15:12] - 4'd4};
        end
        else if (code[13:10] != 4'd0)
        begin
            sub_next = dcv_pkg::SUB_A;
            idx_next = code[13:8] - 6'd4;
        end
        else if (code[9])
        begin
            sub_next = dcv_pkg::SUB_B;
            idx_next = {3'b000, code[8:6]};
        end
        else if (code[8])
        begin
            sub_next = dcv_pkg::SUB_C;
            idx_next = {2'b00, code[7:4]};
        end
        else if (code[7])
        begin
            sub_next = dcv_pkg::SUB_D;
            idx_next = {2'b00, code[6:3]};
        end
        else if (code[6])
        begin
            sub_next = dcv_pkg::SUB_E;
            idx_next = {2'b00, code[5:2]};
        end
        else if (code[5])
        begin
            sub_next = dcv_pkg::SUB_F;
            idx_next = {2'b00, code[4:1]};
        end
        else if (code[4])
        begin
            sub_next = dcv_pkg::SUB_G;
            idx_next = {2'b00, code[3:0]};
        end
    end

    dcv_table u_table
    (
        .sub   (sub1_reg),
        .idx   (idx1_reg),
        .entry (ent_next)
    );

    always_comb
    begin
        sh        = 5'd16 - ent2_reg.len;
        neg       = !ent2_reg.run[6] && win2_reg[sh[3:0]];
        run_next  = ent2_reg.run;
        lvl_next  = neg ? (7'd0 - {1'b0, ent2_reg.mag}) : {1'b0, ent2_reg.mag};
        bits_next = ent2_reg.run[6] ? ent2_reg.len : ent2_reg.len + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            win1_reg <= s_axis_tdata[16:0];
            sub1_reg <= sub_next;
            idx1_reg <= idx_next;
        end
        if (rdy2 && v1_reg)
        begin
            win2_reg <= win1_reg;
            ent2_reg <= ent_next;
            inv2_reg <= (sub1_reg == dcv_pkg::SUB_NONE);
        end
        if (rdy3 && v2_reg)
        begin
            run3_reg  <= run_next;
            lvl3_reg  <= lvl_next;
            bits3_reg <= bits_next;
            inv3_reg  <= inv2_reg;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {5'd0, bits3_reg, lvl3_reg, run3_reg};
    assign m_axis_tuser  = inv3_reg;

    a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && inv3_reg) |->
            (run3_reg == dcv_pkg::RUN_EOB && bits3_reg == 5'd1 && lvl3_reg == 7'd0))
        else $error("invalid window result malformed");

    a_escape_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && run3_reg == dcv_pkg::RUN_ESC) |->
            (bits3_reg == 5'd6 && lvl3_reg == 7'd0 && !inv3_reg))
        else $error("escape result malformed");

    a_level_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && lvl3_reg != 7'd0) |-> (!run3_reg[6] && bits3_reg >= 5'd3))
        else $error("nonzero level on a special code");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(ent2_reg) && $stable(win2_reg)))
        else $error("lookup stage lost its request under stall");

endmodule

// ===== design/dcv_table.sv =====
// Sub-table lookup: run, level magnitude and code length for a selected sub-table entry.
module dcv_table
(
    input  dcv_pkg::sub_t   sub,
    input  logic [5:0]      idx,
    output dcv_pkg::entry_t entry
);

    always_comb
    begin
        case (sub)
            dcv_pkg::SUB_TOP: entry = dcv_pkg::tb_top(idx[3:0]);
            dcv_pkg::SUB_A:   entry = dcv_pkg::tb_a(idx);
            dcv_pkg::SUB_B:   entry = dcv_pkg::tb_b(idx[2:0]);
            dcv_pkg::SUB_C:   entry = dcv_pkg::tb_c(idx[3:0]);
            dcv_pkg::SUB_D:   entry = dcv_pkg::tb_d(idx[3:0]);
            dcv_pkg::SUB_E:   entry = dcv_pkg::tb_e(idx[3:0]);
            dcv_pkg::SUB_F:   entry = dcv_pkg::tb_f(idx[3:0]);
            dcv_pkg::SUB_G:   entry = dcv_pkg::tb_g(idx[3:0]);
            default:          entry = dcv_pkg::ent(64, 0, 1);
        endcase
    end

endmodule
